>>> src/seconds_to_calendar_top_assert.svh
// Assertion macros for the seconds-to-calendar block.
// Used by seconds_to_calendar_top.sv; expects clk_i and rst_ni in scope.
`ifndef SECONDS_TO_CALENDAR_TOP_ASSERT_SVH
`define SECONDS_TO_CALENDAR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// plain clocked property, off during reset
`define S2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// property that must hold whenever cond is true
`define S2C_ASSERT_IF(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);
`else
`define S2C_ASSERT(lbl, prop, msg)
`define S2C_ASSERT_IF(lbl, cond, prop, msg)
`endif
`endif

>>> src/s2c_pkg.sv
// Shared constants, types and the month length table for seconds_to_calendar.
// No dependencies.
package s2c_pkg;

  localparam int unsigned InWidth   = 32;
  localparam int unsigned RemWidth  = 17;
  localparam int unsigned StepWidth = 6;
  localparam int unsigned DaysWidth = 16;
  localparam int unsigned OutTdataW = 48;

  localparam logic [RemWidth-1:0] SecsPerDay  = 17'd86400;
  localparam logic [RemWidth-1:0] SecsPerHour = 17'd3600;
  localparam logic [RemWidth-1:0] SecsPerMin  = 17'd60;
  localparam logic [RemWidth-1:0] DaysPerWeek = 17'd7;

  localparam logic [11:0] BaseYear    = 12'd1970;
  localparam logic [15:0] BaseWeekday = 16'd4;

  typedef struct packed {
    logic                 start;
    logic [StepWidth-1:0] steps;
    logic [RemWidth-1:0]  divisor;
    logic [InWidth-1:0]   dividend;
  } div_cmd_t;

  typedef struct packed {
    logic                done;
    logic [InWidth-1:0]  quo;
    logic [RemWidth-1:0] rem;
  } div_rsp_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> src/seconds_to_calendar_top.sv
// Seconds-since-1970 to Gregorian calendar converter, top level.
// Depends on s2c_pkg, s2c_sdiv and seconds_to_calendar_top_assert.svh.
//
// Input stream: one beat carries a 32-bit unsigned count of seconds since
// 1970-01-01 00:00:00. Output stream: one beat per input beat carrying
// year, month, day, hour, minute, second and day of week (0 = Sunday).
// One conversion at a time. The shared bit-serial divider does, in turn,
// seconds / 86400, rest / 3600, rest / 60 and (days + 4) mod 7. Whole
// years are then stripped one per cycle, then whole months one per cycle
// (the month index goes no higher than 12), and the result is loaded into
// the output register once it is free. A new beat is taken only after the
// result is loaded, when the sequencer is back in idle.
// s_axis_tready is high whenever no conversion is running, even while a
// result still waits in the output register; a finished conversion is
// held in the sequencer until the output register is free, so a stalled
// receiver only delays the next result and nothing is lost.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// m_axis_tvalid; the block keeps no state between conversions.
`include "seconds_to_calendar_top_assert.svh"
module seconds_to_calendar_top import s2c_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: total_seconds[31:0]
  input  logic [InWidth-1:0]   s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  //        second[37:32], weekday[40:38], zero[47:41]
  output logic [OutTdataW-1:0] m_axis_tdata
);

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDDay  = 3'd1; // seconds / 86400
  localparam logic [2:0] StDHour = 3'd2; // rest / 3600
  localparam logic [2:0] StDMin  = 3'd3; // rest / 60
  localparam logic [2:0] StWDay  = 3'd4; // (days + 4) mod 7
  localparam logic [2:0] StYear  = 3'd5; // strip whole years
  localparam logic [2:0] StMonth = 3'd6; // strip whole months
  localparam logic [2:0] StDone  = 3'd7; // wait for output register

  logic [2:0] state_q, state_d;

  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  s2c_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  // working registers
  logic [DaysWidth-1:0] days_q, days_d;
  logic [11:0]          year_q, year_d;
  logic [3:0]           month_q, month_d;
  logic [1:0]           m4_q, m4_d;      // year mod 4
  logic [6:0]           m100_q, m100_d;  // year mod 100
  logic [8:0]           m400_q, m400_d;  // year mod 400
  logic [4:0]           hour_q, hour_d;
  logic [5:0]           minute_q, minute_d;
  logic [5:0]           second_q, second_d;
  logic [2:0]           weekday_q, weekday_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_data_q, out_data_d;

  logic                 leap;
  logic [8:0]           year_len;
  logic [4:0]           mon_len;
  logic                 out_free;
  logic [DaysWidth-1:0] wday_dvd;

  assign leap     = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign year_len = leap ? 9'd366 : 9'd365;
  // February gains a day in leap years
  assign mon_len  = month_len(month_q) + {4'd0, (month_q == 4'd2) && leap};
  assign out_free = !out_valid_q || m_axis_tready;
  assign wday_dvd = days_q + BaseWeekday;

  assign s_axis_tready = (state_q == StIdle);

  always_comb begin
    state_d   = state_q;
    days_d    = days_q;
    year_d    = year_q;
    month_d   = month_q;
    m4_d      = m4_q;
    m100_d    = m100_q;
    m400_d    = m400_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    weekday_d = weekday_q;
    div_cmd   = '0;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          div_cmd.start    = 1'b1;
          div_cmd.steps    = StepWidth'(InWidth);
          div_cmd.divisor  = SecsPerDay;
          div_cmd.dividend = s_axis_tdata;
          state_d          = StDDay;
        end
      end
      StDDay: begin
        if (div_rsp.done) begin
          days_d           = div_rsp.quo[DaysWidth-1:0];
          // 17-bit time of day, left-aligned for a 17-step division
          div_cmd.start    = 1'b1;
          div_cmd.steps    = StepWidth'(RemWidth);
          div_cmd.divisor  = SecsPerHour;
          div_cmd.dividend = {div_rsp.rem, {(InWidth-RemWidth){1'b0}}};
          state_d          = StDHour;
        end
      end
      StDHour: begin
        if (div_rsp.done) begin
          hour_d           = div_rsp.quo[4:0];
          div_cmd.start    = 1'b1;
          div_cmd.steps    = StepWidth'(12);
          div_cmd.divisor  = SecsPerMin;
          div_cmd.dividend = {div_rsp.rem[11:0], 20'd0};
          state_d          = StDMin;
        end
      end
      StDMin: begin
        if (div_rsp.done) begin
          minute_d         = div_rsp.quo[5:0];
          second_d         = div_rsp.rem[5:0];
          div_cmd.start    = 1'b1;
          div_cmd.steps    = StepWidth'(DaysWidth);
          div_cmd.divisor  = DaysPerWeek;
          div_cmd.dividend = {wday_dvd, {(InWidth-DaysWidth){1'b0}}};
          state_d          = StWDay;
        end
      end
      StWDay: begin
        if (div_rsp.done) begin
          weekday_d = div_rsp.rem[2:0];
          year_d    = BaseYear;
          m4_d      = 2'd2;    // 1970 mod 4
          m100_d    = 7'd70;   // 1970 mod 100
          m400_d    = 9'd370;  // 1970 mod 400
          state_d   = StYear;
        end
      end
      StYear: begin
        if (days_q < {7'd0, year_len}) begin
          month_d = 4'd1;
          state_d = StMonth;
        end else begin
          days_d = days_q - {7'd0, year_len};
          year_d = year_q + 12'd1;
          m4_d   = m4_q + 2'd1;
          m100_d = (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
          m400_d = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
        end
      end
      StMonth: begin
        // December takes whatever is left
        if ((days_q < {11'd0, mon_len}) || (month_q >= 4'd12)) begin
          state_d = StDone;
        end else begin
          days_d  = days_q - {11'd0, mon_len};
          month_d = month_q + 4'd1;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, weekday_q, second_q, minute_q, hour_q,
                         days_q[4:0] + 5'd1, month_q, year_q};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q     <= days_d;
    year_q     <= year_d;
    month_q    <= month_d;
    m4_q       <= m4_d;
    m100_q     <= m100_d;
    m400_q     <= m400_d;
    hour_q     <= hour_d;
    minute_q   <= minute_d;
    second_q   <= second_d;
    weekday_q  <= weekday_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // divider finishes only while the sequencer waits on it
  `S2C_ASSERT_IF(a_div_done_in_div_state, div_rsp.done, (state_q == StDDay) || (state_q == StDHour) || (state_q == StDMin) || (state_q == StWDay), "divider done outside a division step")
  // year loop never runs past the top of the input range
  `S2C_ASSERT_IF(a_year_range, state_q == StYear, year_q <= 12'd2106, "year beyond 2106")
  // month counter stays a real month
  `S2C_ASSERT_IF(a_month_range, state_q == StMonth, (month_q >= 4'd1) && (month_q <= 4'd12), "month out of range")
  // day of month left over fits in 1..31
  `S2C_ASSERT_IF(a_day_range, state_q == StDone, days_q < 16'd31, "day of month out of range")
  // a fresh result only lands when the output register is free
  `S2C_ASSERT_IF(a_no_overwrite, out_valid_q && !m_axis_tready, ##1 $stable(out_data_q), "pending result overwritten")

endmodule

>>> src/s2c_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on s2c_pkg (div_cmd_t, div_rsp_t, widths).
module s2c_sdiv import s2c_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  logic [StepWidth-1:0] cnt_q, cnt_d;
  logic [RemWidth-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic [InWidth-1:0]   quo_q, quo_d, dvd_q, dvd_d;
  logic                 done_q, done_d;

  logic [RemWidth:0] trial, diff;
  logic              ge;

  assign trial = {rem_q, dvd_q[InWidth-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (cnt_q != '0) begin
      rem_d  = ge ? diff[RemWidth-1:0] : trial[RemWidth-1:0];
      quo_d  = {quo_q[InWidth-2:0], ge};
      dvd_d  = {dvd_q[InWidth-2:0], 1'b0};
      cnt_d  = cnt_q - StepWidth'(1);
      done_d = (cnt_q == StepWidth'(1));
    end else if (cmd_i.start) begin
      cnt_d = cmd_i.steps;
      rem_d = '0;
      quo_d = '0;
      dvd_d = cmd_i.dividend;
      dvs_d = cmd_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
